>>> src/ilie_pkg.sv
// Shared constants, types and word conversions for the indexed list.
package ilie_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = 5;
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 104;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_READ   = 3'd4
  } ilie_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } ilie_status_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic                  do_app;
    logic                  do_ins;
    logic                  do_ers;
    logic [CMP_W-1:0]      idx;
    logic [CMP_W-1:0]      cnt;
    logic [DATA_WIDTH-1:0] word;
  } ilie_bcast_t;

  // Sign-extend the 32-bit request value, then keep the stored width.
  function automatic logic [DATA_WIDTH-1:0] to_word(input logic [31:0] v);
    logic [63:0] e;
    e = {{32{v[31]}}, v};
    return e[DATA_WIDTH-1:0];
  endfunction

  // A stored word goes out as its low 32 bits, zero-filled when narrower.
  function automatic logic [31:0] to_out(input logic [DATA_WIDTH-1:0] w);
    logic [63:0] e;
    e = 64'(w);
    return e[31:0];
  endfunction

endpackage

>>> src/indexed_list_insert_erase.sv
// Top level of the indexed list: command decode, count, cell row and result register.
//
// A fixed-capacity ordered list held in a row of CAPACITY cells. Each request
// (append, remove last, insert before an index, erase at an index, read at an
// index) is taken at once: every cell compares its position with the index
// and the count and loads its own word, its left or right neighbor, or the new
// word, all at the same clock edge. The response (status, read word, count,
// empty flag, first and last words) is held in a pending stage and then leaves
// through a result register; with out_tready held high the block takes one
// request every cycle. Invalid requests (full, empty, index out of range) are
// flagged in status and leave the list unchanged; unknown command codes are
// answered with status ok and change nothing.
module indexed_list_insert_erase (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [2:0] command, [7:3] index, [39:8] value
  input  logic [ilie_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] status, [33:2] read_value, [38:34] count, [39] is_empty,
  // [71:40] first_value, [103:72] last_value
  output logic [ilie_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import ilie_pkg::*;

  logic [2:0]            cmd;
  logic [IDX_W-1:0]      idx_in;
  logic [CMP_W-1:0]      idx;
  logic [CMP_W-1:0]      n;
  logic                  accept;

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  pend_r, pend_nxt;
  ilie_status_t          p_status_r, status_nxt;
  logic [31:0]           p_rd_r, rd_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_load;

  logic                  do_app, do_ins, do_ers, do_read;
  ilie_bcast_t           bc;

  logic [DATA_WIDTH-1:0] cell_val  [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_last [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_sel, last_sel;

  logic [63:0]           cnt_ext;
  logic                  empty;
  logic [31:0]           first_o, last_o;

  assign cmd    = in_tdata[2:0];
  assign idx_in = in_tdata[7:3];
  assign idx    = CMP_W'(idx_in);
  assign n      = CMP_W'(count_r);

  // The pending stage moves on whenever the result register is free or drained.
  assign out_load  = pend_r && (!out_valid_r || out_tready);
  assign in_tready = !pend_r || out_load;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    status_nxt = ST_OK;
    count_nxt  = count_r;
    do_app     = 1'b0;
    do_ins     = 1'b0;
    do_ers     = 1'b0;
    do_read    = 1'b0;
    case (cmd)
      CMD_APPEND: begin
        if (n >= CMP_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else begin
          do_app    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_INSERT: begin
        if (idx > n) begin
          status_nxt = ST_RANGE;
        end else if (n >= CMP_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_ERASE: begin
        if (idx >= n) begin
          status_nxt = ST_RANGE;
        end else begin
          do_ers    = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (idx >= n) begin
          status_nxt = ST_RANGE;
        end else begin
          do_read = 1'b1;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Before a request the count is the old one; while a result is formed it
  // is the updated one, which is what the last-word select needs.
  always_comb begin
    bc.do_app = accept && do_app;
    bc.do_ins = accept && do_ins;
    bc.do_ers = accept && do_ers;
    bc.idx    = idx;
    bc.cnt    = n;
    bc.word   = to_word(in_tdata[39:8]);
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_v, right_v;
    if (g == 0) begin : g_first
      assign left_v = cell_val[g];
    end else begin : g_mid_l
      assign left_v = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_v = cell_val[g];
    end else begin : g_mid_r
      assign right_v = cell_val[g+1];
    end
    ilie_cell u_cell (
      .clk       (clk),
      .bc        (bc),
      .pos       (CMP_W'(g)),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (cell_val[g]),
      .rd_val    (cell_rd[g]),
      .last_val  (cell_last[g])
    );
  end

  // At most one cell matches, so the selects are plain OR trees.
  always_comb begin
    rd_sel   = '0;
    last_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_sel   = rd_sel | cell_rd[i];
      last_sel = last_sel | cell_last[i];
    end
  end

  assign rd_nxt  = do_read ? to_out(rd_sel) : 32'd0;
  assign cnt_ext = 64'(count_r);
  assign empty   = (count_r == '0);
  assign first_o = empty ? 32'd0 : to_out(cell_val[0]);
  assign last_o  = empty ? 32'd0 : to_out(last_sel);

  always_comb begin
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {last_o, first_o, empty, cnt_ext[4:0], p_rd_r, p_status_r};
      pend_nxt      = 1'b0;
    end
    if (accept) begin
      pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_status_r <= status_nxt;
      p_rd_r     <= rd_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> src/ilie_cell.sv
// One position of the list: holds a word and shifts with its neighbors.
module ilie_cell (
  input  logic                           clk,
  input  ilie_pkg::ilie_bcast_t          bc,
  input  logic [ilie_pkg::CMP_W-1:0]     pos,
  input  logic [ilie_pkg::DATA_WIDTH-1:0] left_val,
  input  logic [ilie_pkg::DATA_WIDTH-1:0] right_val,
  output logic [ilie_pkg::DATA_WIDTH-1:0] val,
  output logic [ilie_pkg::DATA_WIDTH-1:0] rd_val,
  output logic [ilie_pkg::DATA_WIDTH-1:0] last_val
);
  import ilie_pkg::*;

  logic [DATA_WIDTH-1:0] val_r;
  logic [DATA_WIDTH-1:0] val_nxt;
  logic [CMP_W-1:0]      last_pos;

  always_comb begin
    val_nxt = val_r;
    if (bc.do_app && pos == bc.cnt) begin
      val_nxt = bc.word;
    end else if (bc.do_ins) begin
      if (pos == bc.idx) begin
        val_nxt = bc.word;
      end else if (pos > bc.idx) begin
        val_nxt = left_val;
      end
    end else if (bc.do_ers && pos >= bc.idx) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  // The count is the one after the last update when the outputs are formed.
  assign last_pos = bc.cnt - CMP_W'(1);
  assign val      = val_r;
  assign rd_val   = (pos == bc.idx) ? val_r : '0;
  assign last_val = (pos == last_pos && bc.cnt != '0) ? val_r : '0;

endmodule
